// ===== design/refcounted_page_frame_allocator_unit_assert.svh =====
// Assertion macros for the allocator checker.
`ifndef REFCOUNTED_PAGE_FRAME_ALLOCATOR_UNIT_ASSERT_SVH
`define REFCOUNTED_PAGE_FRAME_ALLOCATOR_UNIT_ASSERT_SVH

// Checked only while reset is low.
`define RCPFA_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every edge, reset included.
`define RCPFA_CHECK_ANY(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/rcpfa_pkg.sv =====
// Shared types and constants of the page-frame allocator.
package rcpfa_pkg;

  localparam int NUM_PAGES_DEF        = 16384;
  localparam int PAGE_OFFSET_BITS_DEF = 12;
  localparam int COUNT_WIDTH_DEF      = 16;

  localparam int OP_W      = 3;
  localparam int STATUS_W  = 3;
  localparam int ADDR_W    = 32;
  localparam int REFCNT_W  = 16;
  localparam int LIMIT_W   = 15;
  localparam int CFG_IDX_W = 1;

  localparam int S_FIELDS_W = OP_W + ADDR_W;
  localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
  localparam int M_FIELDS_W = STATUS_W + ADDR_W + REFCNT_W;
  localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;
  localparam int M_PAD_W    = M_TDATA_W - M_FIELDS_W;

  // Bit positions of the result fields in m_tdata
  localparam int M_ADDR_LSB = STATUS_W;
  localparam int M_CNT_LSB  = STATUS_W + ADDR_W;

  localparam logic [LIMIT_W-1:0] LOW_LIMIT_RST  = '0;
  localparam logic [LIMIT_W-1:0] HIGH_LIMIT_RST = LIMIT_W'(16384);

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC = 3'd0,
    OP_FREE  = 3'd1,
    OP_INC   = 3'd2,
    OP_DEC   = 3'd3,
    OP_READ  = 3'd4
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK     = 3'd0,
    STAT_OOM    = 3'd1,
    STAT_BAD    = 3'd2,
    STAT_SHARED = 3'd3,
    STAT_FULL   = 3'd4
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LOW_LIMIT  = 1'd0,
    REG_HIGH_LIMIT = 1'd1
  } cfg_reg_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } cnt_ctrl_t;

  typedef struct packed {
    logic rd_en;
    logic push;
    logic pop;
  } stk_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } stk_stat_t;

endpackage

// ===== design/refcounted_page_frame_allocator_unit.sv =====
// Accepted items read the count and stack memories at the accepting edge; the
// write-back edge then loads the output register. A new item is taken only after
// the last one has been written back, and a result held by the sink stalls the
// write-back of the count and stack memories.
// Reset: the count memory is cleared by a sweep over all NUM_PAGES entries; s_tready
// rises once the sweep ends. Config writes are taken whenever reset is low.
module refcounted_page_frame_allocator_unit import rcpfa_pkg::*; #(
  parameter int NUM_PAGES        = NUM_PAGES_DEF,
  parameter int PAGE_OFFSET_BITS = PAGE_OFFSET_BITS_DEF,
  parameter int COUNT_WIDTH      = COUNT_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,   // operation, phys_address
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata,   // status, page_address, ref_count
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [LIMIT_W-1:0]   cfg_data
);

  localparam int PAGE_W = $clog2(NUM_PAGES);
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

  typedef enum logic [2:0] {
    S_CLEAR = 3'b001,
    S_IDLE  = 3'b010,
    S_EXEC  = 3'b100
  } state_t;

  state_t state, state_next;

  logic [LIMIT_W-1:0] low_limit;
  logic [LIMIT_W-1:0] high_limit;

  op_t               op_q;
  logic [ADDR_W-1:0] addr_q;

  logic                accept;
  logic                commit;
  logic [ADDR_W-1:0]   in_addr;
  logic [ADDR_W-1:0]   in_page;

  // execute-stage decode
  logic [ADDR_W-1:0]   page_q;
  logic [PAGE_W-1:0]   page_idx;
  logic                in_range;
  logic                free_ok;

  cnt_ctrl_t              cnt_ctrl;
  logic [COUNT_WIDTH-1:0] cnt_rd;
  logic [PAGE_W-1:0]      cnt_wr_page;
  logic [COUNT_WIDTH-1:0] cnt_wr_val;
  logic                   cnt_wr;
  logic                   cnt_busy;

  stk_cmd_t          stk_cmd;
  stk_stat_t         stk_stat;
  logic [PAGE_W-1:0] stk_top_page;
  logic              push;
  logic              pop;

  logic [PAGE_W+PAGE_OFFSET_BITS-1:0] alloc_wide;

  status_t                res_status;
  logic [ADDR_W-1:0]      res_addr;
  logic [COUNT_WIDTH-1:0] res_cnt;

  status_t             out_status;
  logic [ADDR_W-1:0]   out_addr;
  logic [REFCNT_W-1:0] out_cnt;
  logic                out_valid;

  // config port
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      low_limit  <= LOW_LIMIT_RST;
      high_limit <= HIGH_LIMIT_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_LOW_LIMIT:  low_limit  <= cfg_data;
        REG_HIGH_LIMIT: high_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  // input side
  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid & s_tready;
  assign in_addr  = s_tdata[OP_W +: ADDR_W];
  assign in_page  = in_addr >> PAGE_OFFSET_BITS;

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q   <= op_t'(s_tdata[OP_W-1:0]);
      addr_q <= in_addr;
    end
  end

  assign commit = (state == S_EXEC) && (!out_valid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: if (!cnt_busy) state_next = S_IDLE;
      S_IDLE:  if (accept) state_next = S_EXEC;
      S_EXEC:  if (commit) state_next = S_IDLE;
      default: state_next = S_CLEAR;
    endcase
  end

  // execute: data from both memories is valid here
  assign page_q     = addr_q >> PAGE_OFFSET_BITS;
  assign page_idx   = page_q[PAGE_W-1:0];
  assign in_range   = page_q < ADDR_W'(NUM_PAGES);
  assign free_ok    = (addr_q[PAGE_OFFSET_BITS-1:0] == '0) && in_range &&
                      (page_q >= ADDR_W'(low_limit)) && (page_q < ADDR_W'(high_limit));
  assign alloc_wide = {stk_top_page, {PAGE_OFFSET_BITS{1'b0}}};

  always_comb begin
    res_status  = STAT_OK;
    res_addr    = '0;
    res_cnt     = '0;
    cnt_wr      = 1'b0;
    cnt_wr_page = page_idx;
    cnt_wr_val  = '0;
    push        = 1'b0;
    pop         = 1'b0;
    unique case (op_q)
      OP_ALLOC: begin
        if (stk_stat.empty) begin
          res_status = STAT_OOM;
        end else begin
          pop         = 1'b1;
          cnt_wr      = 1'b1;
          cnt_wr_page = stk_top_page;
          cnt_wr_val  = COUNT_WIDTH'(1);
          res_addr    = ADDR_W'(alloc_wide);
          res_cnt     = COUNT_WIDTH'(1);
        end
      end
      OP_FREE: begin
        priority if (!free_ok) begin
          res_status = STAT_BAD;
        end else if (cnt_rd > COUNT_WIDTH'(1)) begin
          cnt_wr     = 1'b1;
          cnt_wr_val = cnt_rd - COUNT_WIDTH'(1);
          res_status = STAT_SHARED;
          res_cnt    = cnt_wr_val;
        end else if (stk_stat.full) begin
          res_status = STAT_FULL;
          res_cnt    = cnt_rd;
        end else begin
          cnt_wr = 1'b1;
          push   = 1'b1;
        end
      end
      OP_INC, OP_DEC, OP_READ: begin
        if (!in_range) begin
          res_status = STAT_BAD;
        end else begin
          res_cnt = cnt_rd;
          if (op_q == OP_INC && cnt_rd != CNT_MAX) begin
            cnt_wr     = 1'b1;
            cnt_wr_val = cnt_rd + COUNT_WIDTH'(1);
            res_cnt    = cnt_wr_val;
          end else if (op_q == OP_DEC && cnt_rd != '0) begin
            cnt_wr     = 1'b1;
            cnt_wr_val = cnt_rd - COUNT_WIDTH'(1);
            res_cnt    = cnt_wr_val;
          end
        end
      end
      default: ;
    endcase
  end

  assign cnt_ctrl.rd_en = accept;
  assign cnt_ctrl.wr_en = commit & cnt_wr;
  assign stk_cmd.rd_en  = accept;
  assign stk_cmd.push   = commit & push;
  assign stk_cmd.pop    = commit & pop;

  rcpfa_count_store #(
    .NUM_PAGES   (NUM_PAGES),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_counts (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (cnt_ctrl),
    .rd_page  (in_page[PAGE_W-1:0]),
    .rd_count (cnt_rd),
    .wr_page  (cnt_wr_page),
    .wr_count (cnt_wr_val),
    .busy     (cnt_busy)
  );

  rcpfa_free_stack #(
    .NUM_PAGES (NUM_PAGES)
  ) u_stack (
    .clk       (clk),
    .rst       (rst),
    .cmd       (stk_cmd),
    .push_page (page_idx),
    .top_page  (stk_top_page),
    .stat      (stk_stat)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_status <= res_status;
      out_addr   <= res_addr;
      out_cnt    <= REFCNT_W'(res_cnt);
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {{M_PAD_W{1'b0}}, out_cnt, out_addr, out_status};

endmodule

// ===== design/rcpfa_count_store.sv =====
// Reference count memory with a clearing sweep after reset.
module rcpfa_count_store import rcpfa_pkg::*; #(
  parameter int NUM_PAGES   = NUM_PAGES_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF,
  localparam int PAGE_W     = $clog2(NUM_PAGES)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  cnt_ctrl_t              ctrl,
  input  logic [PAGE_W-1:0]      rd_page,
  output logic [COUNT_WIDTH-1:0] rd_count,
  input  logic [PAGE_W-1:0]      wr_page,
  input  logic [COUNT_WIDTH-1:0] wr_count,
  output logic                   busy
);

  logic [COUNT_WIDTH-1:0] mem [NUM_PAGES];
  logic                   clearing;
  logic [PAGE_W-1:0]      clr_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_idx  <= '0;
    end else if (clearing) begin
      clr_idx <= clr_idx + PAGE_W'(1);
      if (clr_idx == PAGE_W'(NUM_PAGES - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_idx] <= '0;
    end else if (ctrl.wr_en) begin
      mem[wr_page] <= wr_count;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.rd_en) begin
      rd_count <= mem[rd_page];
    end
  end

  assign busy = clearing;

endmodule

// ===== design/rcpfa_free_stack.sv =====
// LIFO of free page numbers in a memory, with its top pointer.
module rcpfa_free_stack import rcpfa_pkg::*; #(
  parameter int NUM_PAGES = NUM_PAGES_DEF,
  localparam int PAGE_W   = $clog2(NUM_PAGES),
  localparam int TOP_W    = $clog2(NUM_PAGES + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  stk_cmd_t          cmd,
  input  logic [PAGE_W-1:0] push_page,
  output logic [PAGE_W-1:0] top_page,
  output stk_stat_t         stat
);

  logic [PAGE_W-1:0] mem [NUM_PAGES];
  logic [TOP_W-1:0]  top;
  logic [TOP_W-1:0]  top_m1;

  assign top_m1 = top - TOP_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      top <= '0;
    end else if (cmd.push) begin
      top <= top + TOP_W'(1);
    end else if (cmd.pop) begin
      top <= top_m1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[top[PAGE_W-1:0]] <= push_page;
    end
  end

  // read is issued with the item, so top here is already settled
  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      top_page <= mem[top_m1[PAGE_W-1:0]];
    end
  end

  assign stat.empty = (top == '0);
  assign stat.full  = (top == TOP_W'(NUM_PAGES));

endmodule

// ===== design/rcpfa_checker.sv =====
// Port-level checker for the allocator, bound to the top level.
`include "refcounted_page_frame_allocator_unit_assert.svh"

module rcpfa_checker import rcpfa_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 s_tvalid,
  input logic                 s_tready,
  input logic                 m_tvalid,
  input logic                 m_tready,
  input logic [M_TDATA_W-1:0] m_tdata
);

  logic [ADDR_W-1:0]   m_addr;
  logic [REFCNT_W-1:0] m_cnt;

  assign m_addr = m_tdata[M_ADDR_LSB +: ADDR_W];
  assign m_cnt  = m_tdata[M_CNT_LSB +: REFCNT_W];

  `RCPFA_CHECK(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result changed while stalled")
  `RCPFA_CHECK(a_one_at_a_time, s_tvalid && s_tready |=> !s_tready, "item accepted while one is in work")
  `RCPFA_CHECK_ANY(a_reset_quiet, rst |=> !m_tvalid && !s_tready, "activity right after reset")
  `RCPFA_CHECK(a_alloc_result, m_tvalid && m_addr != '0 |-> m_tdata[STATUS_W-1:0] == STAT_OK && m_cnt == REFCNT_W'(1), "page address without a clean allocate")

endmodule

bind refcounted_page_frame_allocator_unit rcpfa_checker u_rcpfa_checker (.*);

// ===== test/refcounted_page_frame_allocator_unit_tb.sv =====
// Self-checking testbench for the page-frame allocator: shadow allocator, directed cases, random traffic.
module refcounted_page_frame_allocator_unit_tb;
  import rcpfa_pkg::*;

  localparam int STALL_LIMIT = 5 * NUM_PAGES_DEF;  // covers the count-memory clear after reset
  localparam int POOL_N      = 12;
  localparam int MAX_PRINTS  = 100;

  typedef struct packed {
    status_t             status;
    logic [ADDR_W-1:0]   page_address;
    logic [REFCNT_W-1:0] ref_count;
  } alloc_result_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_LOW_LIMIT;
  logic [LIMIT_W-1:0]   cfg_data = '0;

  // shadow allocator state
  logic [13:0]         free_pages [NUM_PAGES_DEF];
  logic [REFCNT_W-1:0] ref_counts [NUM_PAGES_DEF];
  int unsigned         free_depth = 0;
  int unsigned         low_page = LOW_LIMIT_RST;
  int unsigned         high_page = HIGH_LIMIT_RST;

  logic [S_TDATA_W-1:0] item_fifo [$];
  alloc_result_t        expected_results [$];
  int unsigned          pool_pages [POOL_N];
  int                   items_queued = 0;
  int                   items_taken = 0;
  int                   cfg_writes = 0;
  int                   mismatches = 0;
  int                   quiet_cycles = 0;
  logic                 s_taken = 1'b0;
  int                   s_gap = 0;
  int                   s_calm = 0;
  int                   m_hold = 0;
  int                   m_calm = 0;

  refcounted_page_frame_allocator_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic logic [ADDR_W-1:0] page_base(input int unsigned page);
    return page << PAGE_OFFSET_BITS_DEF;
  endfunction

  // Mostly back to back, some short gaps, a few long ones, now and then a run with no gaps.
  function automatic int draw_gap(inout int calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if (r < 3) begin
      calm = $urandom_range(20, 150);
      return 0;
    end
    if (r < 70) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  // Applies one operation to the shadow state and returns the result it gives.
  function alloc_result_t allocator_step(input logic [OP_W-1:0] op,
                                         input logic [ADDR_W-1:0] addr);
    alloc_result_t r;
    int unsigned   page;
    logic [13:0]   popped;
    r = '{STAT_OK, '0, '0};
    page = addr >> PAGE_OFFSET_BITS_DEF;
    case (op)
      OP_ALLOC: begin
        if (free_depth == 0) begin
          r.status = STAT_OOM;
        end else begin
          free_depth--;
          popped = free_pages[free_depth];
          ref_counts[popped] = 1;
          r.page_address = page_base(32'(popped));
          r.ref_count = 1;
        end
      end
      OP_FREE: begin
        if (addr[PAGE_OFFSET_BITS_DEF-1:0] != 0 || page >= NUM_PAGES_DEF ||
            page < low_page || page >= high_page) begin
          r.status = STAT_BAD;
        end else if (ref_counts[page] > 1) begin
          ref_counts[page]--;
          r.status = STAT_SHARED;
          r.ref_count = ref_counts[page];
        end else if (free_depth >= NUM_PAGES_DEF) begin
          r.status = STAT_FULL;
          r.ref_count = ref_counts[page];
        end else begin
          ref_counts[page] = 0;
          free_pages[free_depth] = page[13:0];
          free_depth++;
        end
      end
      OP_INC, OP_DEC, OP_READ: begin
        if (page >= NUM_PAGES_DEF) begin
          r.status = STAT_BAD;
        end else begin
          if (op == OP_INC && ref_counts[page] != '1) ref_counts[page]++;
          else if (op == OP_DEC && ref_counts[page] != 0) ref_counts[page]--;
          r.ref_count = ref_counts[page];
        end
      end
      default: ;  // unused codes leave everything alone
    endcase
    return r;
  endfunction

  task report_mismatch(input string field, input logic [ADDR_W-1:0] got,
                       input logic [ADDR_W-1:0] want);
    if (mismatches < MAX_PRINTS)
      $display("%0t mismatch on %s: got %0h, expected %0h", $time, field, got, want);
    mismatches++;
  endtask

  task send(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] addr);
    item_fifo.push_back(S_TDATA_W'({addr, op}));
    items_queued++;
  endtask

  task wait_idle();
    do @(negedge clk);
    while (!(items_taken == items_queued && expected_results.size() == 0));
  endtask

  task write_reg(input cfg_reg_t idx, input int unsigned value);
    int target;
    target = cfg_writes + 1;
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= LIMIT_W'(value);
    do @(negedge clk);
    while (cfg_writes != target);
    cfg_valid <= 1'b0;
  endtask

  // Waits for the block to drain, sets both limits and picks a page pool for them.
  task set_limits(input int unsigned lo, input int unsigned hi);
    int unsigned top;
    wait_idle();
    write_reg(REG_LOW_LIMIT, lo);
    write_reg(REG_HIGH_LIMIT, hi);
    top = (hi < NUM_PAGES_DEF) ? hi : NUM_PAGES_DEF;
    for (int i = 0; i < POOL_N; i++)
      pool_pages[i] = (lo < top) ? $urandom_range(lo, top - 1)
                                 : $urandom_range(0, NUM_PAGES_DEF - 1);
    if (lo < top) begin
      pool_pages[0] = lo;
      pool_pages[1] = top - 1;
    end
  endtask

  // Mostly legal traffic on a small pool of pages, so pages get shared, pushed twice
  // and reallocated; the rest is noise.
  task queue_mixed_op();
    int unsigned       sel;
    logic [ADDR_W-1:0] base;
    sel = $urandom_range(0, 99);
    base = page_base(pool_pages[$urandom_range(0, POOL_N - 1)]);
    if (sel < 25) send(OP_ALLOC, $urandom);
    else if (sel < 55) send(OP_FREE, base);
    else if (sel < 70) send(OP_INC, base | $urandom_range(0, 4095));
    else if (sel < 80) send(OP_DEC, base);
    else if (sel < 88) send(OP_READ, base | $urandom_range(0, 4095));
    else if (sel < 91) send(OP_W'(OP_READ + 1 + $urandom_range(0, 2)), $urandom);
    else if (sel < 94) send(OP_FREE, base | $urandom_range(1, 4095));
    else if (sel < 97) send(OP_FREE, page_base($urandom_range(0, NUM_PAGES_DEF - 1)));
    else send(OP_W'($urandom_range(OP_INC, OP_READ)), $urandom);
  endtask

  // drives s_tvalid and m_tready
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      m_tready <= 1'b0;
    end else begin
      if (!s_tvalid || s_taken) begin
        if (s_gap > 0) begin
          s_gap--;
          s_tvalid <= 1'b0;
        end else if (item_fifo.size() > 0) begin
          s_tdata  <= item_fifo.pop_front();
          s_tvalid <= 1'b1;
          s_gap = draw_gap(s_calm);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
      if (m_hold > 0) begin
        m_hold--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        m_hold = draw_gap(m_calm);
      end
    end
  end

  // handshakes, prediction, checking, watchdog
  always @(posedge clk) begin
    alloc_result_t want;
    s_taken <= s_tvalid && s_tready;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        cfg_writes++;
        case (cfg_index)
          REG_LOW_LIMIT:  low_page = 32'(cfg_data);
          REG_HIGH_LIMIT: high_page = 32'(cfg_data);
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        items_taken++;
        expected_results.push_back(allocator_step(s_tdata[OP_W-1:0],
                                                  s_tdata[OP_W +: ADDR_W]));
      end
      if (m_tvalid && m_tready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", m_tdata[ADDR_W-1:0], '0);
        end else begin
          want = expected_results.pop_front();
          if (m_tdata[STATUS_W-1:0] != want.status)
            report_mismatch("status", ADDR_W'(m_tdata[STATUS_W-1:0]), ADDR_W'(want.status));
          if (m_tdata[M_ADDR_LSB +: ADDR_W] != want.page_address)
            report_mismatch("page_address", m_tdata[M_ADDR_LSB +: ADDR_W],
                            want.page_address);
          if (m_tdata[M_CNT_LSB +: REFCNT_W] != want.ref_count)
            report_mismatch("ref_count", ADDR_W'(m_tdata[M_CNT_LSB +: REFCNT_W]),
                            ADDR_W'(want.ref_count));
        end
      end
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    int unsigned phase_lo [6];
    int unsigned phase_hi [6];
    for (int i = 0; i < NUM_PAGES_DEF; i++) begin
      ref_counts[i] = '0;
      free_pages[i] = '0;
    end
    repeat (4) @(negedge clk);
    rst <= 1'b0;

    // directed: empty stack, bad addresses, double push, shared page, decrement at zero
    set_limits(16, NUM_PAGES_DEF);
    send(OP_ALLOC, '0);                          // empty stack
    send(OP_READ, '1);                           // page beyond memory
    send(OP_FREE, page_base(20) | 1);            // misaligned
    send(OP_FREE, page_base(3));                 // below low limit
    send(OP_FREE, page_base(NUM_PAGES_DEF));     // beyond memory
    send(OP_FREE, page_base(20));
    send(OP_FREE, page_base(21));
    send(OP_FREE, page_base(20));                // same page pushed twice
    send(OP_ALLOC, '1);
    send(OP_ALLOC, '0);
    send(OP_INC, page_base(21));
    send(OP_FREE, page_base(21));                // shared page
    send(OP_FREE, page_base(21));
    send(OP_DEC, page_base(22));                 // decrement at zero
    send(OP_INC, page_base(0) | 12'hfff);        // inc ignores alignment
    send(OP_READ, '0);
    send(OP_DEC, '0);
    for (int o = OP_READ + 1; o < (1 << OP_W); o++) send(OP_W'(o), $urandom);
    send(OP_INC, '1);
    send(OP_ALLOC, '0);
    send(OP_FREE, page_base(NUM_PAGES_DEF - 1)); // top page under high limit

    phase_lo = '{0, 5461, 0, NUM_PAGES_DEF, 0, 0};
    phase_hi = '{NUM_PAGES_DEF, 10922, 0, NUM_PAGES_DEF, 0, 0};
    phase_lo[4] = $urandom_range(0, NUM_PAGES_DEF);
    phase_hi[4] = $urandom_range(phase_lo[4], NUM_PAGES_DEF);
    phase_lo[5] = $urandom_range(0, NUM_PAGES_DEF);
    phase_hi[5] = $urandom_range(0, NUM_PAGES_DEF);
    for (int ph = 0; ph < 6; ph++) begin
      set_limits(phase_lo[ph], phase_hi[ph]);
      repeat (200) queue_mixed_op();
    end

    wait_idle();
    repeat (20) @(negedge clk);
    if (mismatches == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
